// ----- sv/fcf_pkg.sv -----
// Package for the feedback comb filter: shared constants, register index codes
// and the issue struct passed from the slot controller to the datapath.
// No dependencies.
`timescale 1ns / 1ps

package fcf_pkg;

  // Defaults of the top-level parameters.
  localparam int LINE_DEPTH_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF = 24;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_DELAY    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FB_GAIN  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_GAIN = 2'd2;

  // Register widths and reset values.
  localparam int DELAY_BITS = 12;
  localparam int GAIN_BITS  = 16;
  localparam logic signed [GAIN_BITS-1:0] OUT_GAIN_RESET = 16'sd4096;

  // Fixed-point formats: feedback gain is Q0.16, output gain is Q4.12.
  localparam int FB_FRAC  = 16;
  localparam int OUT_FRAC = 12;
  localparam int FB_HALF  = 1 << (FB_FRAC - 1);
  localparam int OUT_HALF = 1 << (OUT_FRAC - 1);

  // Result queue.
  localparam int OUTQ_DEPTH    = 4;
  localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);

  // Per-word flags handed to the datapath when a word is accepted.
  typedef struct packed {
    logic valid;   // a word is accepted in this cycle
    logic old_ok;  // the write slot holds a written value
    logic rd_ok;   // the read slot holds a written value
    logic kzero;   // zero delay: the read slot is the slot just written
  } fcf_issue_t;

endpackage

// ----- sv/fcf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module fcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/fcf_ctrl.sv -----
// Slot controller of the feedback comb filter: ring slots, fill count, input
// pacing, words in flight and delay-line addressing. Depends on fcf_pkg.
`timescale 1ns / 1ps

module fcf_ctrl #(
  parameter int LINE_DEPTH = fcf_pkg::LINE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [fcf_pkg::DELAY_BITS-1:0]  delay_samples,
  input  logic                            delay_write,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            out_take,
  output fcf_pkg::fcf_issue_t             issue,
  output logic [$clog2(LINE_DEPTH)-1:0]   rd_addr,
  output logic                            wr_en,
  output logic [$clog2(LINE_DEPTH)-1:0]   wr_addr
);
  import fcf_pkg::*;

  localparam int AW   = $clog2(LINE_DEPTH);
  localparam int LW   = $clog2(LINE_DEPTH + 1);
  localparam int KMAX = LINE_DEPTH - 2;
  localparam int CW   = OUTQ_CNT_BITS;

  logic [LW-1:0] keff;
  logic [LW-1:0] len;
  logic [AW-1:0] ws;
  logic [AW-1:0] rs;
  logic [AW-1:0] ws_next;
  logic [AW-1:0] rs_next;
  logic [LW-1:0] ws_inc;
  logic [LW-1:0] rs_inc;
  logic [LW-1:0] fill;
  logic [LW-1:0] fill_next;
  logic          phase;
  logic          reload_pend;
  logic [CW-1:0] outstanding;
  logic [CW-1:0] outstanding_next;
  logic          in_acc;
  logic          acc_a;
  logic          acc_b;
  logic [AW-1:0] ws_a;
  logic [AW-1:0] rs_a;
  logic [AW-1:0] ws_b;

  // Effective delay saturates at the line size minus two.
  always_comb begin
    if (32'(delay_samples) > 32'(KMAX)) begin
      keff = LW'(KMAX);
    end else begin
      keff = LW'(delay_samples);
    end
    len = keff + LW'(2);
  end

  always_comb begin
    ws_inc  = LW'(ws) + LW'(1);
    rs_inc  = LW'(rs) + LW'(1);
    ws_next = (ws_inc == len) ? '0 : ws_inc[AW-1:0];
    rs_next = (rs_inc == len) ? '0 : rs_inc[AW-1:0];
    fill_next = (fill == len) ? fill : fill + LW'(1);
  end

  assign in_stall = rst | phase | reload_pend | (outstanding == CW'(OUTQ_DEPTH));
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    issue.valid  = in_acc;
    issue.old_ok = LW'(ws_next) < fill;
    issue.rd_ok  = LW'(rs_next) < fill_next;
    issue.kzero  = (keff == '0);
  end

  always_comb begin
    unique case ({in_acc, out_take})
      2'b10:   outstanding_next = outstanding + CW'(1);
      2'b01:   outstanding_next = outstanding - CW'(1);
      default: outstanding_next = outstanding;
    endcase
  end

  // Read port: the old write-slot value in the accept cycle, the read slot in the
  // cycle after. Pacing keeps these two reads from colliding.
  assign rd_addr = acc_a ? rs_a : ws_next;
  assign wr_en   = acc_b;
  assign wr_addr = ws_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      ws          <= AW'(1);
      rs          <= AW'(1);
      fill        <= '0;
      phase       <= 1'b0;
      reload_pend <= 1'b0;
      outstanding <= '0;
      acc_a       <= 1'b0;
      acc_b       <= 1'b0;
    end else begin
      phase       <= in_acc;
      reload_pend <= delay_write;
      acc_a       <= in_acc;
      acc_b       <= acc_a;
      outstanding <= outstanding_next;
      if (reload_pend) begin
        ws   <= AW'(keff + LW'(1));
        rs   <= AW'(1);
        fill <= '0;
      end else if (in_acc) begin
        ws   <= ws_next;
        rs   <= rs_next;
        fill <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ws_a <= ws_next;
      rs_a <= rs_next;
    end
    ws_b <= ws_a;
  end

  a_cap : assert property (@(posedge clk) disable iff (rst)
    outstanding <= CW'(OUTQ_DEPTH))
    else $error("more words in flight than the result queue holds");

  a_pace : assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_acc)
    else $error("words accepted in back-to-back cycles");

  a_slot : assert property (@(posedge clk) disable iff (rst)
    !reload_pend |-> (LW'(ws) < len) && (LW'(rs) < len))
    else $error("ring slot outside the ring");

endmodule

// ----- sv/fcf_datapath.sv -----
// Arithmetic pipeline of the feedback comb filter: feedback multiply, store
// value, output multiply, rounding and saturation. Depends on fcf_pkg.
`timescale 1ns / 1ps

module fcf_datapath #(
  parameter int SAMPLE_BITS = fcf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fcf_pkg::fcf_issue_t                    issue,
  input  logic signed [SAMPLE_BITS-1:0]          sample_in,
  input  logic [fcf_pkg::GAIN_BITS-1:0]          feedback_gain,
  input  logic signed [fcf_pkg::GAIN_BITS-1:0]   output_gain,
  input  logic signed [SAMPLE_BITS-1:0]          rd_data,
  output logic signed [SAMPLE_BITS-1:0]          wr_data,
  output logic                                   push,
  output logic signed [SAMPLE_BITS-1:0]          push_data
);
  import fcf_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int PFW = SB + GAIN_BITS + 1;
  localparam int PO  = SB + GAIN_BITS;
  localparam int OW  = PO - OUT_FRAC;

  logic                 v_a, v_b, v_c, v_d;
  logic signed [SB-1:0] x_a, x_b;
  logic                 old_ok_a;
  logic                 rd_ok_a, rd_ok_b;
  logic                 kzero_a, kzero_b;
  logic signed [SB-1:0] old_sel;
  logic signed [PFW-1:0] prod_fb;
  logic signed [PFW-1:0] fb_sum;
  logic signed [SB:0]    fb;
  logic signed [SB+1:0]  w_wide;
  logic                  w_ovf;
  logic signed [SB-1:0]  y_sel;
  logic signed [SB-1:0]  y_c;
  logic signed [PO-1:0]  prod_o;
  logic signed [PO-1:0]  o_sum;
  logic signed [OW-1:0]  o_sh;
  logic                  o_ovf;

  // Stage A: old content of the write slot arrives and is scaled.
  assign old_sel = old_ok_a ? rd_data : '0;

  // Stage B: stored value with round-half-up and saturation.
  always_comb begin
    fb_sum  = prod_fb + PFW'(FB_HALF);
    fb      = $signed(fb_sum[PFW-1:FB_FRAC]);
    w_wide  = (SB+2)'(x_b) + (SB+2)'(fb);
    w_ovf   = !((&w_wide[SB+1:SB-1]) || !(|w_wide[SB+1:SB-1]));
    wr_data = w_ovf ? {w_wide[SB+1], {(SB-1){~w_wide[SB+1]}}} : w_wide[SB-1:0];
    if (kzero_b) begin
      y_sel = wr_data;
    end else if (rd_ok_b) begin
      y_sel = rd_data;
    end else begin
      y_sel = '0;
    end
  end

  // Stage D: output rounding and saturation into the result queue.
  always_comb begin
    o_sum     = prod_o + PO'(OUT_HALF);
    o_sh      = $signed(o_sum[PO-1:OUT_FRAC]);
    o_ovf     = !((&o_sh[OW-1:SB-1]) || !(|o_sh[OW-1:SB-1]));
    push_data = o_ovf ? {o_sh[OW-1], {(SB-1){~o_sh[OW-1]}}} : o_sh[SB-1:0];
    push      = v_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else begin
      v_a <= issue.valid;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (issue.valid) begin
      x_a      <= sample_in;
      old_ok_a <= issue.old_ok;
      rd_ok_a  <= issue.rd_ok;
      kzero_a  <= issue.kzero;
    end
    if (v_a) begin
      x_b     <= x_a;
      rd_ok_b <= rd_ok_a;
      kzero_b <= kzero_a;
      prod_fb <= PFW'(old_sel) * PFW'($signed({1'b0, feedback_gain}));
    end
    if (v_b) begin
      y_c <= y_sel;
    end
    if (v_c) begin
      prod_o <= PO'(y_c) * PO'(output_gain);
    end
  end

endmodule

// ----- sv/fcf_outq.sv -----
// Result queue of the feedback comb filter: a few entries in flip-flops that
// decouple the pipeline from the output stall. Depends on fcf_pkg.
`timescale 1ns / 1ps

module fcf_outq #(
  parameter int SAMPLE_BITS = fcf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic signed [SAMPLE_BITS-1:0] push_data,
  output logic                          pop_valid,
  input  logic                          pop_stall,
  output logic signed [SAMPLE_BITS-1:0] pop_data
);
  import fcf_pkg::*;

  localparam int PW = OUTQ_PTR_BITS;
  localparam int CW = OUTQ_CNT_BITS;

  logic signed [SAMPLE_BITS-1:0] mem [OUTQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign pop       = pop_valid & ~pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push |-> count < CW'(OUTQ_DEPTH))
    else $error("result pushed into a full queue");

  a_count_up : assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == CW'($past(count) + CW'(1)))
    else $error("queue count did not rise on push");

  a_count_down : assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == CW'($past(count) - CW'(1)))
    else $error("queue count did not fall on pop");

endmodule

// ----- sv/feedback_comb_filter.sv -----
// Feedback comb filter, top level: configuration registers and the delay line.
// The input never takes words in back-to-back cycles, since the delay line's
// single read port serves two reads per word; the words in flight are limited
// to the depth of the result queue. Reset clears the registers and empties the
// line logically through a fill count, with no clearing pass; a delay write
// stalls the input while the ring reloads.
// Depends on fcf_pkg, fcf_ctrl, fcf_ram, fcf_datapath and fcf_outq.
`timescale 1ns / 1ps

module feedback_comb_filter #(
  parameter int LINE_DEPTH  = fcf_pkg::LINE_DEPTH_DEF,
  parameter int SAMPLE_BITS = fcf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [fcf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [fcf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        sample_out
);
  import fcf_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);

  // Configuration registers. A delay write also restarts the ring, which the
  // slot controller does in the cycle after the write.
  logic [DELAY_BITS-1:0]       delay_samples;
  logic [GAIN_BITS-1:0]        feedback_gain;
  logic signed [GAIN_BITS-1:0] output_gain;
  logic                        delay_write;

  fcf_issue_t                  issue;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               wr_addr;
  logic                        wr_en;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] wr_data;
  logic                        push;
  logic signed [SAMPLE_BITS-1:0] push_data;
  logic                        out_take;

  assign delay_write = cfg_write && (cfg_index == REG_DELAY);
  assign out_take    = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= '0;
      feedback_gain <= '0;
      output_gain   <= OUT_GAIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DELAY:    delay_samples <= cfg_data[DELAY_BITS-1:0];
        REG_FB_GAIN:  feedback_gain <= cfg_data[GAIN_BITS-1:0];
        REG_OUT_GAIN: output_gain   <= $signed(cfg_data[GAIN_BITS-1:0]);
        default: begin
          // Unused index: the write is dropped.
        end
      endcase
    end
  end

  // The slot controller owns the write and read slots of the ring, a fill
  // count that stands in for clearing the line, and the input pacing.
  fcf_ctrl #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .delay_samples(delay_samples),
    .delay_write  (delay_write),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_take     (out_take),
    .issue        (issue),
    .rd_addr      (rd_addr),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr)
  );

  // The delay line itself. Entries are never read as data before being
  // written: the fill count masks them to zero.
  fcf_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(LINE_DEPTH)
  ) u_line (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Feedback multiply in the first stage, stored value and write-back in the
  // second, output multiply in the third, rounding in the fourth. With zero
  // delay the stored value is forwarded straight to the output path.
  fcf_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .issue        (issue),
    .sample_in    (sample_in),
    .feedback_gain(feedback_gain),
    .output_gain  (output_gain),
    .rd_data      (rd_data),
    .wr_data      (wr_data),
    .push         (push),
    .push_data    (push_data)
  );

  // Results wait here for the consumer; the controller never lets more words
  // be in flight than this queue can hold, so the pipeline never stalls.
  fcf_outq #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop_valid(out_valid),
    .pop_stall(out_stall),
    .pop_data (sample_out)
  );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for feedback_comb_filter: directed and random sample words
// are checked against a built-in model of the comb filter under several register settings.
// Depends on fcf_pkg and the feedback_comb_filter RTL.
`timescale 1ns / 1ps

module testbench;
  import fcf_pkg::*;

  localparam int LINE_DEPTH  = LINE_DEPTH_DEF;
  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  // Index 3 names no register; writes to it must leave the filter alone.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int MAX_TAP = LINE_DEPTH - 2;
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  // Cycles allowed after the last expected word before the next phase or the end.
  localparam int SETTLE_CYCLES = 12;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  sample_t                  sample_in;
  logic                     out_valid;
  logic                     out_stall;
  sample_t                  sample_out;

  feedback_comb_filter #(
    .LINE_DEPTH (LINE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out)
  );

  // 8 ns clock; the first rising edge falls at 4 ns.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample words waiting to be sent, and filter outputs waiting to be seen.
  sample_t sample_queue[$];
  sample_t expected_out[$];
  int      mismatches;
  // Idle and stall rates in percent, changed only between phases.
  int      send_idle_pct;
  int      stall_pct;

  // Model of the filter: its own copy of the registers, the ring and both slots.
  sample_t                     line_model[LINE_DEPTH];
  logic [DELAY_BITS-1:0]       delay_reg;
  logic [GAIN_BITS-1:0]        fb_gain_reg;
  logic signed [GAIN_BITS-1:0] out_gain_reg;
  int unsigned                 tap_len;
  int unsigned                 ring_len;
  int unsigned                 wr_slot;
  int unsigned                 rd_slot;
  sample_t                     want;

  function automatic longint clamp_sample(longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  // A delay write acts like a fresh setup: the ring is emptied and the slots
  // are placed so that the first write lands in slot 0 and the read slot
  // trails it by the tap length.
  function void reload_ring();
    tap_len  = (delay_reg > MAX_TAP) ? MAX_TAP : delay_reg;
    ring_len = tap_len + 2;
    foreach (line_model[i]) line_model[i] = '0;
    wr_slot = ring_len - 1;
    rd_slot = (2 * ring_len - 1 - tap_len) % ring_len;
  endfunction

  // One sample through the comb: feed back the old slot content, store the
  // saturated sum, then scale the tap. Both products round half up.
  function sample_t comb_predict(sample_t x);
    longint prior;
    longint fed;
    longint w;
    longint y;
    wr_slot = (wr_slot + 1 >= ring_len) ? 0 : wr_slot + 1;
    prior = line_model[wr_slot];
    fed = (prior * longint'(fb_gain_reg) + FB_HALF) >>> FB_FRAC;
    w = clamp_sample(longint'(x) + fed);
    line_model[wr_slot] = sample_t'(w);
    rd_slot = (rd_slot + 1 >= ring_len) ? 0 : rd_slot + 1;
    y = (longint'(line_model[rd_slot]) * longint'(out_gain_reg) + OUT_HALF) >>> OUT_FRAC;
    return sample_t'(clamp_sample(y));
  endfunction

  // Driver. A word accepted at this edge is run through the model right away;
  // a new word is offered only once the previous one is gone, so a stalled
  // word never changes.
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      sample_in <= '0;
    end else begin
      if (in_valid && !in_stall) expected_out.push_back(comb_predict(sample_in));
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          sample_in <= sample_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every accepted output word is matched against the oldest
  // prediction; the stall for the next edge is drawn afresh each cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_out.size() == 0) begin
          mismatches++;
          $error("sample_out: expected nothing, got %0d", sample_out);
        end else begin
          want = expected_out.pop_front();
          if (sample_out !== want) begin
            mismatches++;
            $error("sample_out: expected %0d, got %0d", want, sample_out);
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Register writes go out one per edge; the model takes the value at once,
  // which is safe because writes only happen while the filter is idle.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_DELAY: begin
        delay_reg = data[DELAY_BITS-1:0];
        reload_ring();
      end
      REG_FB_GAIN:  fb_gain_reg = data;
      REG_OUT_GAIN: out_gain_reg = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_gains(logic [GAIN_BITS-1:0] fb, logic [GAIN_BITS-1:0] og);
    write_reg(REG_FB_GAIN, fb);
    write_reg(REG_OUT_GAIN, og);
  endtask

  // Random samples lean on the rails and on small values, where rounding
  // and saturation show up, with plain random words for the rest.
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0:       return sample_t'(SAMPLE_MAX);
      1:       return sample_t'(SAMPLE_MIN);
      2, 3:    return sample_t'(int'($urandom_range(8191)) - 4096);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic queue_random(int count);
    repeat (count) sample_queue.push_back(pick_sample());
  endtask

  // Hold off until the sender is empty and every predicted word has come
  // back, then let the pipeline run on for SETTLE_CYCLES to show any extra word.
  task automatic drain();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || expected_out.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_DELAY;
    cfg_data      = '0;
    in_valid      = 1'b0;
    sample_in     = '0;
    out_stall     = 1'b0;
    mismatches    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    delay_reg     = '0;
    fb_gain_reg   = '0;
    out_gain_reg  = OUT_GAIN_RESET;
    reload_ring();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero delay, no feedback, unity output, so each word
    // should come straight through. Rails and alternating bit patterns.
    sample_queue.push_back(sample_t'(SAMPLE_MAX));
    sample_queue.push_back(sample_t'(SAMPLE_MIN));
    sample_queue.push_back(sample_t'(0));
    sample_queue.push_back(sample_t'(-1));
    sample_queue.push_back(sample_t'(1));
    sample_queue.push_back(sample_t'(24'h555555));
    sample_queue.push_back(sample_t'(24'hAAAAAA));
    drain();

    // Full feedback and the largest positive output gain: repeated rail
    // inputs push both the stored sum and the output into saturation.
    // The unused index gets a write too, which must change nothing.
    write_reg(REG_DELAY, 16'd1);
    write_gains(16'hFFFF, 16'h7FFF);
    write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
    end_writes();
    repeat (6) sample_queue.push_back(sample_t'(SAMPLE_MAX));
    repeat (4) sample_queue.push_back(sample_t'(SAMPLE_MIN));
    repeat (2) sample_queue.push_back(sample_t'(0));
    drain();

    // Zero delay with half feedback and the most negative output gain: the
    // read slot is the one just written.
    write_reg(REG_DELAY, 16'd0);
    write_gains(16'h8000, 16'h8000);
    end_writes();
    sample_queue.push_back(sample_t'(1));
    sample_queue.push_back(sample_t'(-1));
    sample_queue.push_back(sample_t'(SAMPLE_MAX));
    sample_queue.push_back(sample_t'(SAMPLE_MIN));
    repeat (2) sample_queue.push_back(sample_t'(0));
    drain();

    // Random phases. Sender mostly idle first.
    send_idle_pct = 80;
    stall_pct     = 0;
    write_reg(REG_DELAY, 16'd7);
    write_gains(GAIN_BITS'($urandom), 16'd4096);
    end_writes();
    queue_random(80);
    drain();

    // Receiver mostly stalling; a delay beyond the line saturates to the
    // longest tap. Halfway the sender waits for every output to return.
    send_idle_pct = 0;
    stall_pct     = 80;
    write_reg(REG_DELAY, 16'hFFFF);
    write_gains(16'hFFFF, GAIN_BITS'($urandom));
    end_writes();
    queue_random(40);
    drain();
    queue_random(40);
    drain();

    // Both sides idling; a gains-only write midway keeps the ring contents.
    send_idle_pct = 38;
    stall_pct     = 38;
    write_reg(REG_DELAY, 16'd2);
    write_gains(GAIN_BITS'($urandom), GAIN_BITS'($urandom));
    end_writes();
    queue_random(50);
    drain();
    write_gains(16'hC000, 16'hF000);
    end_writes();
    queue_random(50);
    drain();

    // Random delay at full speed.
    send_idle_pct = 0;
    stall_pct     = 0;
    write_reg(REG_DELAY, CFG_DATA_BITS'($urandom_range(4095)));
    write_gains(GAIN_BITS'($urandom), GAIN_BITS'($urandom));
    end_writes();
    queue_random(60);
    drain();

    // A short ring, run past a few laps so the feedback path wraps.
    write_reg(REG_DELAY, 16'd17);
    write_gains(16'hF000, 16'd4096);
    end_writes();
    queue_random(50);
    drain();

    if (mismatches == 0) begin
      $display("feedback_comb_filter regression: pass");
    end else begin
      $display("feedback_comb_filter regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("feedback_comb_filter regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
sv/fcf_pkg.sv
sv/fcf_ram.sv
sv/fcf_ctrl.sv
sv/fcf_datapath.sv
sv/fcf_outq.sv
sv/feedback_comb_filter.sv
test/testbench.sv
